FILE: rtl/grs_pkg.sv
// shared types and constants of the gain ramp smoother
package grs_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 22;
    localparam int LENGTH_BITS_DEF    = 16;

    localparam int GAIN_BITS     = 24;
    localparam int GAIN_EXT_BITS = 16;
    localparam int GAIN_NOW_BITS = GAIN_BITS + GAIN_EXT_BITS;
    localparam int DIFF_BITS     = GAIN_NOW_BITS + 1;

    localparam logic [GAIN_BITS-1:0] TARGET_RESET = 24'd4194304;
    localparam int                   LENGTH_RESET = 480;

    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STEP,
        S_MUL,
        S_RND
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/gain_ramp_smoother_top.sv
// top level of the gain ramp smoother: sequencer, gain state, multiply and output register
//
// Usage
//   s_axis carries one request per beat: tdata holds sample_in, tuser[0] is op
//   (0 process a sample, 1 snap the gain to the target) and tuser[1] is
//   frame_start. m_axis returns sample_out in tdata and ramping in tuser.
//   A snap request is taken and returns nothing.
//   A sample request goes from S_IDLE through S_MUL and S_RND to the output
//   register, by way of S_STEP when a ramp step is applied, and of S_DIV and
//   S_STEP when a frame start begins a new ramp; the divider makes one
//   quotient bit a cycle. s_axis_tready is high only while the sequencer
//   is idle, so one request is in work at a time; a result waits in the
//   output register and the next request is accepted meanwhile.
//   If the receiver stalls with a result still pending, the next result
//   holds in the rounding stage until the output register frees.
//   Configuration writes (index 0 target gain, 1 ramp_length) take effect at
//   once; they are to be made while the block is idle, which it does not enforce.
//   Synchronous active-low reset restores unity gain, ramp length 480 and
//   no ramp in progress, and empties the output register.
module gain_ramp_smoother_top #(
    parameter int SAMPLE_BITS    = grs_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = grs_pkg::GAIN_FRAC_BITS_DEF,
    parameter int LENGTH_BITS    = grs_pkg::LENGTH_BITS_DEF,
    parameter int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8,
    parameter int CFG_W          = (grs_pkg::GAIN_BITS > LENGTH_BITS) ?
                                   grs_pkg::GAIN_BITS : LENGTH_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // sample_in
    input  logic [1:0]         s_axis_tuser,   // op, frame_start
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // sample_out
    output logic               m_axis_tuser,   // ramping
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);
    import grs_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic signed [PW:0] HALF = (PW+1)'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [PW:0] SMAX = ((PW+1)'(1) << (SAMPLE_BITS - 1)) - (PW+1)'(1);
    localparam logic signed [PW:0] SMIN = -SMAX - (PW+1)'(1);
    localparam logic signed [GAIN_NOW_BITS+1:0] GMAX =
        {2'b00, {GAIN_NOW_BITS{1'b1}}};
    localparam logic [DIFF_BITS-1:0] STEP_LIM = DIFF_BITS'(1) << (GAIN_NOW_BITS - 1);

    t_state r_state, n_state;

    logic [GAIN_BITS-1:0]     r_target;
    logic [LENGTH_BITS-1:0]   r_length;
    logic [GAIN_NOW_BITS-1:0] r_gain;
    logic [GAIN_BITS-1:0]     r_goal;
    logic [GAIN_NOW_BITS-1:0] r_step;
    logic [LENGTH_BITS-1:0]   r_frames;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [PW-1:0]          r_prod;
    logic                          r_neg;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_ramp;

    logic accept, snap, frame, new_ramp, load_out, div_start;

    logic [LENGTH_BITS-1:0]          len_eff;
    logic signed [DIFF_BITS-1:0]     diff;
    logic [DIFF_BITS-1:0]            diff_mag;
    logic [DIFF_BITS-1:0]            quo;
    t_div_stat                       div_stat;
    logic [GAIN_NOW_BITS-1:0]        step_sat;
    logic signed [GAIN_NOW_BITS+1:0] g_sum;
    logic [GAIN_NOW_BITS-1:0]        g_clamp;
    logic [LENGTH_BITS-1:0]          frames_dec;
    logic signed [PW:0]              prod_x;
    logic signed [PW:0]              rnd;
    logic signed [PW:0]              shf;
    logic [SAMPLE_BITS-1:0]          sat;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign snap     = s_axis_tuser[0];
    assign frame    = s_axis_tuser[1];
    assign new_ramp = frame && (r_target != r_goal);
    assign len_eff  = (r_length == '0) ? LENGTH_BITS'(1) : r_length;
    assign diff     = $signed({1'b0, r_target, {GAIN_EXT_BITS{1'b0}}}) -
                      $signed({1'b0, r_gain});
    assign diff_mag = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

    grs_div #(
        .LENGTH_BITS (LENGTH_BITS),
        .DW          (DIFF_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff_mag),
        .i_divisor  (len_eff),
        .o_quotient (quo),
        .o_stat     (div_stat)
    );

    always_comb begin
        if (r_neg) begin
            step_sat = (quo > STEP_LIM) ? STEP_LIM[GAIN_NOW_BITS-1:0] :
                       GAIN_NOW_BITS'(-quo);
        end else begin
            step_sat = (quo >= STEP_LIM) ? GAIN_NOW_BITS'(STEP_LIM - DIFF_BITS'(1)) :
                       quo[GAIN_NOW_BITS-1:0];
        end
    end

    assign g_sum = $signed({2'b00, r_gain}) + $signed({{2{r_step[GAIN_NOW_BITS-1]}}, r_step});
    always_comb begin
        if (g_sum < 0) begin
            g_clamp = '0;
        end else if (g_sum > GMAX) begin
            g_clamp = GMAX[GAIN_NOW_BITS-1:0];
        end else begin
            g_clamp = g_sum[GAIN_NOW_BITS-1:0];
        end
    end
    assign frames_dec = r_frames - 1'b1;

    assign prod_x = (PW+1)'(r_prod);
    assign rnd    = prod_x + HALF;
    assign shf    = rnd >>> GAIN_FRAC_BITS;
    always_comb begin
        if (shf > SMAX) begin
            sat = SMAX[SAMPLE_BITS-1:0];
        end else if (shf < SMIN) begin
            sat = SMIN[SAMPLE_BITS-1:0];
        end else begin
            sat = shf[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !snap) begin
                    priority if (new_ramp) begin
                        n_state = S_DIV;
                    end else if (frame && r_frames != '0) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_DIV:  if (div_stat.done) n_state = S_STEP;
            S_STEP: n_state = S_MUL;
            S_MUL:  n_state = S_RND;
            S_RND:  if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                div_start     = s_axis_tvalid && !snap && new_ramp;
            end
            S_RND:   load_out = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_target <= TARGET_RESET;
            r_length <= LENGTH_BITS'(LENGTH_RESET);
            r_goal   <= TARGET_RESET;
            r_gain   <= {TARGET_RESET, {GAIN_EXT_BITS{1'b0}}};
            r_step   <= '0;
            r_frames <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET: r_target <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_LENGTH: r_length <= i_cfg_data[LENGTH_BITS-1:0];
                    default: ;
                endcase
            end
            if (accept && snap) begin
                r_goal   <= r_target;
                r_gain   <= {r_target, {GAIN_EXT_BITS{1'b0}}};
                r_step   <= '0;
                r_frames <= '0;
            end else if (div_start) begin
                r_goal   <= r_target;
                r_frames <= len_eff;
            end
            if (r_state == S_DIV && div_stat.done) begin
                r_step <= step_sat;
            end
            if (r_state == S_STEP) begin
                r_frames <= frames_dec;
                r_gain   <= (frames_dec == '0) ? {r_goal, {GAIN_EXT_BITS{1'b0}}} : g_clamp;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
            r_neg    <= diff[DIFF_BITS-1];
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_sample) *
                      PW'($signed({1'b0, r_gain[GAIN_NOW_BITS-1 -: GAIN_BITS]}));
        end
        if (load_out) begin
            r_out_sample <= sat;
            r_out_ramp   <= r_frames != '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_sample);
    assign m_axis_tuser  = r_out_ramp;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !div_stat.busy)
        else $error("request taken while the divider runs");

    a_step_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> r_frames != '0)
        else $error("gain step with no frames left");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || m_axis_tready))
        else $error("pending result overwritten");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> r_state == S_DIV && div_stat.busy)
        else $error("ramp start did not enter the divide state");

endmodule

FILE: rtl/grs_div.sv
// iterative restoring divider, one quotient bit per cycle
module grs_div #(
    parameter int LENGTH_BITS = grs_pkg::LENGTH_BITS_DEF,
    parameter int DW          = grs_pkg::DIFF_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DW-1:0]          i_dividend,
    input  logic [LENGTH_BITS-1:0] i_divisor,
    output logic [DW-1:0]          o_quotient,
    output grs_pkg::t_div_stat     o_stat
);
    import grs_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [LENGTH_BITS-1:0] r_rem;
    logic [LENGTH_BITS-1:0] r_div;
    logic [DW-1:0]          r_quo;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [LENGTH_BITS:0] rem_sh;
    logic [LENGTH_BITS:0] rem_sub;
    logic                 ge;

    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[LENGTH_BITS-1:0] : rem_sh[LENGTH_BITS-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
